>>> rtl/core/cts_pkg.sv
// Shared constants, tables and types of the cosine Taylor series block.
package cts_pkg;

  localparam int ANGLE_FRAC_BITS = 24;
  localparam int MAX_TERMS       = 8;
  localparam int WORK_BITS       = 30;

  localparam int ANGLE_W = 32;
  localparam int COS_W   = 18;
  localparam int CNT_W   = 5;
  localparam int TOL_W   = 16;
  localparam int DW      = 32;
  localparam int PW      = 2 * DW;
  localparam int SUM_W   = 34;
  localparam int K_W     = 4;
  localparam int D_W     = 10;

  localparam logic [TOL_W-1:0] TOL_RESET = 16'd7;

  localparam logic [63:0] PI_Q60  = 64'h3243_F6A8_885A_308D;
  localparam int          PI_DROP = 60 - ANGLE_FRAC_BITS;

  localparam logic [DW-1:0] PI_F =
    DW'((PI_Q60 + (64'd1 << (PI_DROP - 1))) >> PI_DROP);
  localparam logic [DW-1:0] TWO_PI_F =
    DW'((PI_Q60 + (64'd1 << (PI_DROP - 2))) >> (PI_DROP - 1));
  localparam logic [DW-1:0] HALF_PI_F =
    DW'((PI_Q60 + (64'd1 << PI_DROP)) >> (PI_DROP + 1));

  localparam int REM_STEPS = $clog2(int'((64'd1 << 31) / 64'(TWO_PI_F)) + 1);
  localparam int RED_CW    = (REM_STEPS > 1) ? $clog2(REM_STEPS) : 1;
  localparam logic [DW-1:0] RED_DIV0 = DW'(64'(TWO_PI_F) << (REM_STEPS - 1));

  localparam int X_SHIFT = WORK_BITS - ANGLE_FRAC_BITS;
  localparam int TOL_SHIFT = WORK_BITS - 16;

  localparam logic [DW-1:0] ONE_W   = DW'(64'd1 << WORK_BITS);
  localparam logic [PW-1:0] RND_W   = PW'(64'd1 << (WORK_BITS - 1));
  localparam logic [SUM_W-1:0] RND_OUT = SUM_W'(64'd1 << (WORK_BITS - 17));
  localparam logic [16:0] COS_ONE = 17'd65536;

  // Divisor (2k-1)(2k) of series step k and its truncated reciprocal 2^32/d.
  localparam logic [D_W-1:0] DIV_D [16] = '{
    10'd1,   10'd2,   10'd12,  10'd30,  10'd56,  10'd90,  10'd132, 10'd182,
    10'd240, 10'd306, 10'd380, 10'd462, 10'd552, 10'd650, 10'd756, 10'd870
  };

  localparam logic [DW-1:0] RECIP [16] = '{
    32'hFFFF_FFFF,
    32'((64'd1 << 32) / 64'd2),   32'((64'd1 << 32) / 64'd12),
    32'((64'd1 << 32) / 64'd30),  32'((64'd1 << 32) / 64'd56),
    32'((64'd1 << 32) / 64'd90),  32'((64'd1 << 32) / 64'd132),
    32'((64'd1 << 32) / 64'd182), 32'((64'd1 << 32) / 64'd240),
    32'((64'd1 << 32) / 64'd306), 32'((64'd1 << 32) / 64'd380),
    32'((64'd1 << 32) / 64'd462), 32'((64'd1 << 32) / 64'd552),
    32'((64'd1 << 32) / 64'd650), 32'((64'd1 << 32) / 64'd756),
    32'((64'd1 << 32) / 64'd870)
  };

  typedef enum logic [11:0] {
    ST_IDLE  = 12'b0000_0000_0001,
    ST_RED   = 12'b0000_0000_0010,
    ST_FOLD1 = 12'b0000_0000_0100,
    ST_FOLD2 = 12'b0000_0000_1000,
    ST_SQ    = 12'b0000_0001_0000,
    ST_X2    = 12'b0000_0010_0000,
    ST_ACC   = 12'b0000_0100_0000,
    ST_NRM   = 12'b0000_1000_0000,
    ST_RCP   = 12'b0001_0000_0000,
    ST_CHK   = 12'b0010_0000_0000,
    ST_COR   = 12'b0100_0000_0000,
    ST_FIN   = 12'b1000_0000_0000
  } cts_state_t;

  typedef struct packed {
    logic start;
    logic out_free;
  } cts_ctl_t;

  typedef struct packed {
    logic idle;
    logic done;
  } cts_sts_t;

endpackage

>>> rtl/core/cts_mul.sv
// Shared 32x32 unsigned multiplier with a registered product.
module cts_mul (
  input  logic                     clk,
  input  logic [cts_pkg::DW-1:0]   op_a,
  input  logic [cts_pkg::DW-1:0]   op_b,
  output logic [cts_pkg::PW-1:0]   prod
);
  import cts_pkg::*;

  logic [PW-1:0] prod_r;

  always_ff @(posedge clk) begin
    prod_r <= PW'(op_a) * PW'(op_b);
  end

  assign prod = prod_r;

endmodule

>>> rtl/core/cts_core.sv
// Sequencer and datapath: range reduction, series evaluation and output rounding.
module cts_core (
  input  logic                            clk,
  input  logic                            rst_n,
  input  cts_pkg::cts_ctl_t               ctl,
  input  logic signed [cts_pkg::ANGLE_W-1:0] angle,
  input  logic [cts_pkg::TOL_W-1:0]       tolerance,
  output cts_pkg::cts_sts_t               sts,
  output logic signed [cts_pkg::COS_W-1:0] cosine,
  output logic [cts_pkg::CNT_W-1:0]       terms_used
);
  import cts_pkg::*;

  cts_state_t        state_r, state_nxt;
  logic [DW-1:0]     rem_r, rem_nxt;
  logic [DW-1:0]     div_r, div_nxt;
  logic [RED_CW-1:0] step_r, step_nxt;
  logic              neg_r, neg_nxt;
  logic [DW-1:0]     x2_r, x2_nxt;
  logic [DW-1:0]     term_r, term_nxt;
  logic signed [SUM_W-1:0] sum_r, sum_nxt;
  logic [CNT_W-1:0]  cnt_r, cnt_nxt;
  logic [DW-1:0]     n_r, n_nxt;
  logic [DW-1:0]     q_r, q_nxt;

  logic [DW-1:0]     op_a, op_b;
  logic [PW-1:0]     prod;
  logic [DW-1:0]     mag;
  logic [K_W-1:0]    k_idx;
  logic [D_W-1:0]    div_d;
  logic [DW-1:0]     thr;
  logic [DW-1:0]     rem_chk;
  logic [SUM_W-1:0]  amag;
  logic [SUM_W-1:0]  rnd;
  logic [16:0]       omag;
  logic              out_neg;

  cts_mul u_mul (
    .clk  (clk),
    .op_a (op_a),
    .op_b (op_b),
    .prod (prod)
  );

  assign mag     = angle[ANGLE_W-1] ? (~DW'(angle) + DW'(1)) : DW'(angle);
  assign k_idx   = cnt_r[K_W-1:0];
  assign div_d   = DIV_D[k_idx];
  assign thr     = DW'(tolerance) << TOL_SHIFT;
  assign rem_chk = n_r - prod[DW-1:0];

  assign amag    = sum_r[SUM_W-1] ? SUM_W'(-sum_r) : SUM_W'(sum_r);
  assign rnd     = (amag + RND_OUT) >> (WORK_BITS - 16);
  assign omag    = (rnd > SUM_W'(COS_ONE)) ? COS_ONE : rnd[16:0];
  assign out_neg = neg_r ^ sum_r[SUM_W-1];

  always_comb begin
    op_a = '0;
    op_b = '0;
    case (state_r)
      ST_SQ: begin
        op_a = rem_r << X_SHIFT;
        op_b = rem_r << X_SHIFT;
      end
      ST_ACC: begin
        op_a = term_r;
        op_b = x2_r;
      end
      ST_RCP: begin
        op_a = n_r;
        op_b = RECIP[k_idx];
      end
      ST_CHK: begin
        op_a = prod[PW-1:DW];
        op_b = DW'(div_d);
      end
      default: begin
        op_a = '0;
        op_b = '0;
      end
    endcase
  end

  always_comb begin
    state_nxt = state_r;
    rem_nxt   = rem_r;
    div_nxt   = div_r;
    step_nxt  = step_r;
    neg_nxt   = neg_r;
    x2_nxt    = x2_r;
    term_nxt  = term_r;
    sum_nxt   = sum_r;
    cnt_nxt   = cnt_r;
    n_nxt     = n_r;
    q_nxt     = q_r;
    case (state_r)
      ST_IDLE: begin
        if (ctl.start) begin
          rem_nxt   = mag;
          div_nxt   = RED_DIV0;
          step_nxt  = RED_CW'(REM_STEPS - 1);
          neg_nxt   = 1'b0;
          term_nxt  = ONE_W;
          sum_nxt   = '0;
          cnt_nxt   = '0;
          state_nxt = ST_RED;
        end
      end
      ST_RED: begin
        if (rem_r >= div_r) begin
          rem_nxt = rem_r - div_r;
        end
        div_nxt = div_r >> 1;
        if (step_r == '0) begin
          state_nxt = ST_FOLD1;
        end else begin
          step_nxt = step_r - RED_CW'(1);
        end
      end
      ST_FOLD1: begin
        if (rem_r > PI_F) begin
          rem_nxt = TWO_PI_F - rem_r;
        end
        state_nxt = ST_FOLD2;
      end
      ST_FOLD2: begin
        if (rem_r > HALF_PI_F) begin
          rem_nxt = PI_F - rem_r;
          neg_nxt = 1'b1;
        end
        state_nxt = ST_SQ;
      end
      ST_SQ: begin
        state_nxt = ST_X2;
      end
      ST_X2: begin
        x2_nxt    = DW'((prod + RND_W) >> WORK_BITS);
        state_nxt = ST_ACC;
      end
      ST_ACC: begin
        if (cnt_r[0]) begin
          sum_nxt = sum_r - $signed(SUM_W'(term_r));
        end else begin
          sum_nxt = sum_r + $signed(SUM_W'(term_r));
        end
        cnt_nxt = cnt_r + CNT_W'(1);
        if ((term_r > thr) && (cnt_nxt < CNT_W'(MAX_TERMS))) begin
          state_nxt = ST_NRM;
        end else begin
          state_nxt = ST_FIN;
        end
      end
      ST_NRM: begin
        n_nxt     = DW'((prod + RND_W) >> WORK_BITS) + DW'(div_d >> 1);
        state_nxt = ST_RCP;
      end
      ST_RCP: begin
        state_nxt = ST_CHK;
      end
      ST_CHK: begin
        q_nxt     = prod[PW-1:DW];
        state_nxt = ST_COR;
      end
      ST_COR: begin
        term_nxt  = (rem_chk >= DW'(div_d)) ? (q_r + DW'(1)) : q_r;
        state_nxt = ST_ACC;
      end
      ST_FIN: begin
        if (ctl.out_free) begin
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_ff @(posedge clk) begin
    rem_r  <= rem_nxt;
    div_r  <= div_nxt;
    step_r <= step_nxt;
    neg_r  <= neg_nxt;
    x2_r   <= x2_nxt;
    term_r <= term_nxt;
    sum_r  <= sum_nxt;
    cnt_r  <= cnt_nxt;
    n_r    <= n_nxt;
    q_r    <= q_nxt;
  end

  assign sts.idle   = (state_r == ST_IDLE);
  assign sts.done   = (state_r == ST_FIN) && ctl.out_free;
  assign cosine     = out_neg ? -$signed(COS_W'(omag)) : $signed(COS_W'(omag));
  assign terms_used = cnt_r;

endmodule

>>> rtl/core/cosine_taylor_series_top.sv
// Top level of the cosine Taylor series block: channels, tolerance register, output register.
//
//   channel   direction  handshake            payload
//   in_       input      in_valid / in_stall   in_angle (Q8.24 radians)
//   out_      output     out_valid / out_stall out_cosine (Q1.16), out_terms_used
//   cfg_      input      cfg_wr_en             cfg_wr_data (tolerance, Q16)
//
// After its transfer an item holds the block until its result moves to the output register;
// that time grows with N, terms_used, at most eight; the shared 32x32 multiplier, used three
// times per series term, and the bit-per-cycle reduction modulo 2*pi set it.
// Reset is synchronous and active low; it empties the output register and sets
// the tolerance to 7. A finished result waits in the output register while the next
// item is taken; the sequencer holds its last step while that register is full and stalled.
module cosine_taylor_series_top (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_valid,
  output logic                                in_stall,
  input  logic signed [cts_pkg::ANGLE_W-1:0]  in_angle,
  output logic                                out_valid,
  input  logic                                out_stall,
  output logic signed [cts_pkg::COS_W-1:0]    out_cosine,
  output logic [cts_pkg::CNT_W-1:0]           out_terms_used,
  input  logic                                cfg_wr_en,
  input  logic [cts_pkg::TOL_W-1:0]           cfg_wr_data
);
  import cts_pkg::*;

  logic [TOL_W-1:0]        tolerance_r;
  logic                    out_valid_r;
  logic signed [COS_W-1:0] out_cosine_r;
  logic [CNT_W-1:0]        out_terms_r;

  cts_ctl_t                ctl;
  cts_sts_t                sts;
  logic signed [COS_W-1:0] core_cosine;
  logic [CNT_W-1:0]        core_terms;

  assign ctl.start    = in_valid && sts.idle;
  assign ctl.out_free = !out_valid_r || !out_stall;

  cts_core u_core (
    .clk        (clk),
    .rst_n      (rst_n),
    .ctl        (ctl),
    .angle      (in_angle),
    .tolerance  (tolerance_r),
    .sts        (sts),
    .cosine     (core_cosine),
    .terms_used (core_terms)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tolerance_r <= TOL_RESET;
    end else if (cfg_wr_en) begin
      tolerance_r <= cfg_wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (sts.done) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (sts.done) begin
      out_cosine_r <= core_cosine;
      out_terms_r  <= core_terms;
    end
  end

  assign in_stall       = !sts.idle;
  assign out_valid      = out_valid_r;
  assign out_cosine     = out_cosine_r;
  assign out_terms_used = out_terms_r;

endmodule

>>> rtl/core/cts_checker.sv
// Port-level assertions for the cosine Taylor series block and their bind.
module cts_checker (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_valid,
  input  logic                                in_stall,
  input  logic                                out_valid,
  input  logic                                out_stall,
  input  logic signed [cts_pkg::COS_W-1:0]    out_cosine,
  input  logic [cts_pkg::CNT_W-1:0]           out_terms_used
);
  import cts_pkg::*;

  // The block works on one item at a time, so a transfer in closes the input.
  a_busy_after_transfer: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && !in_stall) |=> in_stall)
    else $error("input not stalled after a transfer");

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_stall) |=> (out_valid && $stable(out_cosine)
                                  && $stable(out_terms_used)))
    else $error("stalled result changed or dropped");

  a_cos_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> ((out_cosine <= 18'sd65536) && (out_cosine >= -18'sd65536)))
    else $error("cosine outside plus or minus one");

  a_terms_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> ((out_terms_used >= CNT_W'(1))
                   && (out_terms_used <= CNT_W'(MAX_TERMS))))
    else $error("terms_used out of range");

  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result present after reset");

endmodule

bind cosine_taylor_series_top cts_checker u_cts_checker (.*);

>>> tb/sv/tb_cosine_taylor_series_top.sv
// Self-checking testbench for the cosine Taylor series block with a bit-exact cosine predictor.
module tb_cosine_taylor_series_top;
  timeunit 1ns;
  timeprecision 1ps;

  import cts_pkg::*;

  localparam int CYCLE_LIMIT = 600000;
  localparam int FB = cts_pkg::ANGLE_FRAC_BITS;
  localparam int WB = 30;
  localparam int DRAIN_CYCLES = 60;
  localparam logic [63:0] PI_60 = 64'h3243_F6A8_885A_308D;
  localparam logic [63:0] PI_Q = (PI_60 + (64'd1 << (59 - FB))) >> (60 - FB);
  localparam logic [63:0] TWO_PI_Q = (PI_60 + (64'd1 << (58 - FB))) >> (59 - FB);
  localparam logic [63:0] HALF_PI_Q = (PI_60 + (64'd1 << (60 - FB))) >> (61 - FB);

  typedef struct {
    logic [ANGLE_W-1:0] angle;
    logic [COS_W-1:0]   cosine;
    logic [CNT_W-1:0]   terms_used;
  } cos_result_t;

  logic                      clk = 1'b0;
  logic                      rst_n = 1'b0;
  logic                      in_valid = 1'b0;
  logic                      in_stall;
  logic signed [ANGLE_W-1:0] in_angle = '0;
  logic                      out_valid;
  logic                      out_stall = 1'b0;
  logic signed [COS_W-1:0]   out_cosine;
  logic [CNT_W-1:0]          out_terms_used;
  logic                      cfg_wr_en = 1'b0;
  logic [TOL_W-1:0]          cfg_wr_data = '0;

  cos_result_t      cos_expected_q[$];
  logic [TOL_W-1:0] tolerance_now = TOL_RESET;
  int               send_gap_pct = 0;
  int               stall_pct = 0;
  int               hold_request = 0;
  int               hold_left = 0;
  int               mismatches = 0;

  cosine_taylor_series_top u_top (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .in_angle       (in_angle),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .out_cosine     (out_cosine),
    .out_terms_used (out_terms_used),
    .cfg_wr_en      (cfg_wr_en),
    .cfg_wr_data    (cfg_wr_data)
  );

  always #6 clk = ~clk;

  function automatic cos_result_t cos_predict(logic [ANGLE_W-1:0] ang, logic [TOL_W-1:0] tol);
    logic [63:0] mag, x, xw, x2, term, thr, dv, p, amag;
    longint      sum, res;
    int          cnt, k;
    logic        flip;
    cos_result_t r;
    mag = ang[ANGLE_W-1] ? (64'h1_0000_0000 - {32'd0, ang}) : {32'd0, ang};
    x = mag % TWO_PI_Q;
    if (x > PI_Q) x = TWO_PI_Q - x;
    flip = 1'b0;
    if (x > HALF_PI_Q) begin
      x = PI_Q - x;
      flip = 1'b1;
    end
    xw = x << (WB - FB);
    x2 = (xw * xw + (64'd1 << (WB - 1))) >> WB;
    thr = {48'd0, tol} << (WB - 16);
    term = 64'd1 << WB;
    sum = longint'(term);
    cnt = 1;
    k = 1;
    while (term > thr && cnt < MAX_TERMS) begin
      dv = 64'((2 * k - 1) * (2 * k));
      p = (term * x2 + (64'd1 << (WB - 1))) >> WB;
      term = (p + dv / 2) / dv;
      if (k % 2 == 1) sum = sum - longint'(term);
      else sum = sum + longint'(term);
      cnt++;
      k++;
    end
    amag = (sum < 0) ? 64'(-sum) : 64'(sum);
    amag = (amag + (64'd1 << (WB - 17))) >> (WB - 16);
    if (amag > 64'd65536) amag = 64'd65536;
    res = (sum < 0) ? -longint'(amag) : longint'(amag);
    if (flip) res = -res;
    if (res > 65536) res = 65536;
    if (res < -65536) res = -65536;
    r.angle = ang;
    r.cosine = res[COS_W-1:0];
    r.terms_used = cnt[CNT_W-1:0];
    return r;
  endfunction

  function automatic logic [ANGLE_W-1:0] pick_angle();
    logic [63:0] m;
    case ($urandom_range(4))
      0: m = 64'($urandom_range(0, 1 << 22));
      1: m = 64'($urandom_range(1, 80)) * HALF_PI_Q + 64'($urandom_range(0, 32)) - 64'd16;
      2: m = 64'($urandom_range(0, 8 << 24));
      default: return $urandom;
    endcase
    return $urandom_range(1) ? -m[ANGLE_W-1:0] : m[ANGLE_W-1:0];
  endfunction

  task automatic send_angle(logic [ANGLE_W-1:0] ang);
    @(negedge clk);
    if ($urandom_range(99) < send_gap_pct) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 6)) @(negedge clk);
    end
    in_valid <= 1'b1;
    in_angle <= ang;
    do @(posedge clk); while (in_stall);
    cos_expected_q.push_back(cos_predict(ang, tolerance_now));
  endtask

  task automatic wait_idle();
    @(negedge clk);
    in_valid <= 1'b0;
    while (cos_expected_q.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic write_tolerance(logic [TOL_W-1:0] tol);
    wait_idle();
    @(negedge clk);
    cfg_wr_en <= 1'b1;
    cfg_wr_data <= tol;
    @(negedge clk);
    cfg_wr_en <= 1'b0;
    tolerance_now = tol;
  endtask

  task automatic test_corner_angles();
    logic [ANGLE_W-1:0] angles[$];
    angles = '{32'd0, 32'd1, 32'hFFFF_FFFF, 32'h7FFF_FFFF, 32'h8000_0000,
               PI_Q[31:0], PI_Q[31:0] - 32'd1, PI_Q[31:0] + 32'd1,
               HALF_PI_Q[31:0], HALF_PI_Q[31:0] - 32'd1, HALF_PI_Q[31:0] + 32'd1,
               TWO_PI_Q[31:0], TWO_PI_Q[31:0] - 32'd1, TWO_PI_Q[31:0] + 32'd1,
               -PI_Q[31:0], 32'(3 * HALF_PI_Q), 32'h0100_0000, 32'hFF00_0000,
               32'h5555_5555, 32'hAAAA_AAAA};
    foreach (angles[i]) send_angle(angles[i]);
  endtask

  task automatic test_tolerance_limits();
    logic [TOL_W-1:0] tols[$];
    tols = '{16'd0, 16'hFFFF, 16'd1};
    foreach (tols[t]) begin
      write_tolerance(tols[t]);
      send_angle(32'd0);
      send_angle(32'h8000_0000);
      send_angle(HALF_PI_Q[31:0]);
      send_angle(PI_Q[31:0] + 32'd1);
      repeat (6) send_angle(pick_angle());
    end
  endtask

  task automatic test_random_angles();
    int gaps[4];
    int stalls[4];
    logic [TOL_W-1:0] tols[4];
    gaps = '{0, 48, 0, 22};
    stalls = '{0, 0, 48, 22};
    tols = '{16'h5555, 16'hAAAA, 16'($urandom), TOL_RESET};
    for (int ph = 0; ph < 4; ph++) begin
      write_tolerance(tols[ph]);
      send_gap_pct = gaps[ph];
      stall_pct = stalls[ph];
      repeat (200) send_angle(pick_angle());
    end
    send_gap_pct = 0;
    stall_pct = 0;
  endtask

  task automatic test_output_backpressure();
    wait_idle();
    hold_request = 400;
    repeat (30) send_angle(pick_angle());
  endtask

  always @(negedge clk) begin
    if (hold_request != 0) begin
      hold_left = hold_request;
      hold_request = 0;
    end
    if (hold_left > 0) begin
      hold_left--;
      out_stall <= 1'b1;
    end else begin
      out_stall <= ($urandom_range(99) < stall_pct);
    end
  end

  always @(posedge clk) begin
    cos_result_t e;
    if (rst_n && out_valid && !out_stall) begin
      if (cos_expected_q.size() == 0) begin
        mismatches++;
        $display("%0t: unexpected result cosine %0d terms %0d", $time, out_cosine,
                 out_terms_used);
      end else begin
        e = cos_expected_q.pop_front();
        if (out_cosine !== e.cosine) begin
          mismatches++;
          $display("%0t: angle %h cosine expected %0d actual %0d", $time, e.angle,
                   $signed(e.cosine), out_cosine);
        end
        if (out_terms_used !== e.terms_used) begin
          mismatches++;
          $display("%0t: angle %h terms_used expected %0d actual %0d", $time, e.angle,
                   e.terms_used, out_terms_used);
        end
      end
    end
  end

  initial begin : watchdog
    int cyc;
    cyc = 0;
    while (cyc < CYCLE_LIMIT) begin
      @(posedge clk);
      cyc++;
    end
    $display("tb_cosine_taylor_series_top NOT OK");
    $finish;
  end

  initial begin
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    test_corner_angles();
    test_tolerance_limits();
    test_random_angles();
    test_output_backpressure();
    wait_idle();
    if (mismatches == 0) begin
      $display("tb_cosine_taylor_series_top OK");
    end else begin
      $display("tb_cosine_taylor_series_top NOT OK");
    end
    $finish;
  end

endmodule

>>> files.f
rtl/core/cts_pkg.sv
rtl/core/cts_mul.sv
rtl/core/cts_core.sv
rtl/core/cosine_taylor_series_top.sv
rtl/core/cts_checker.sv
tb/sv/tb_cosine_taylor_series_top.sv
